// ===== design/printable_run_extractor_unit_defines.svh =====
// Assertion macros shared by the printable run extractor RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef PRINTABLE_RUN_EXTRACTOR_UNIT_DEFINES_SVH
`define PRINTABLE_RUN_EXTRACTOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition must never be true.
`define PRE_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== design/pre_pkg.sv =====
// Shared types and constants of the printable run extractor.
// No dependencies; imported by every module of the block.
`default_nettype none

package pre_pkg;

    localparam int MAX_MIN_LEN = 63;

    localparam int CHAR_W     = 21;
    localparam int BCNT_W     = 3;
    localparam int OFF_W      = 48;
    localparam int MINLEN_W   = 6;
    localparam int RLEN_W     = 7;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;
    localparam int CMDQ_CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_OFFSET = 1'b1;

    localparam logic [MINLEN_W-1:0] MIN_LEN_RESET = 6'd4;

    // Work handed from the front to the back.
    typedef enum logic [1:0] {
        OP_STORE,
        OP_EMIT,
        OP_LINE_END,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [CHAR_W-1:0]  ch;
        logic [IDX_W-1:0]   idx;     // store slot, or buffered count for a flush
        logic [OFF_W-1:0]   offset;  // run start for a flush
        logic               show;    // attach offset on a flush
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_cmdq_status;

    typedef enum logic {
        BK_IDLE,
        BK_FLUSH
    } t_bk_state;

endpackage

`default_nettype wire

// ===== design/pre_front.sv =====
// Front end: accepts characters, tracks byte position and run state, issues commands.
// Depends on pre_pkg.
`default_nettype none

module pre_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pre_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pre_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [pre_pkg::CHAR_W-1:0]    i_char_code,
    input  wire logic [pre_pkg::BCNT_W-1:0]    i_byte_count,
    input  wire logic                          i_printable,
    input  wire logic                          i_decode_error,
    input  wire pre_pkg::t_cmdq_status         i_q_status,
    output logic                               o_push,
    output pre_pkg::t_cmd                      o_cmd
);
    import pre_pkg::*;

    logic [MINLEN_W-1:0] r_min_len;
    logic                r_show_offset;
    logic [RLEN_W-1:0]   r_run_len,   n_run_len;
    logic [OFF_W-1:0]    r_byte_pos,  n_byte_pos;
    logic [OFF_W-1:0]    r_run_start, n_run_start;

    logic              accept;
    logic [RLEN_W-1:0] min_ext;

    always_comb begin
        accept      = i_in_valid && !i_q_status.full;
        min_ext     = {1'b0, r_min_len};
        n_run_len   = r_run_len;
        n_run_start = r_run_start;
        n_byte_pos  = r_byte_pos;
        o_push      = 1'b0;
        o_cmd.op     = OP_STORE;
        o_cmd.ch     = i_char_code;
        o_cmd.idx    = r_run_len[IDX_W-1:0];
        o_cmd.offset = r_run_start;
        o_cmd.show   = r_show_offset;

        if (accept) begin
            n_byte_pos = r_byte_pos + OFF_W'(i_byte_count);
            if (i_decode_error) begin
                // skipped character: only its bytes count
            end else if (!i_printable) begin
                if (r_run_len > min_ext) begin
                    o_push   = 1'b1;
                    o_cmd.op = OP_LINE_END;
                    o_cmd.ch = '0;
                end
                n_run_len = '0;
            end else begin
                if (r_run_len == '0) begin
                    n_run_start = r_byte_pos;
                end
                o_cmd.offset = n_run_start;
                o_push       = 1'b1;
                if (r_run_len < min_ext) begin
                    o_cmd.op  = OP_STORE;
                    n_run_len = r_run_len + 1'b1;
                end else if (r_run_len > min_ext) begin
                    o_cmd.op = OP_EMIT;
                end else begin
                    o_cmd.op  = OP_FLUSH;
                    o_cmd.idx = r_min_len;
                    n_run_len = min_ext + 1'b1;
                end
            end
        end
    end

    assign o_in_stall = i_q_status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len     <= MIN_LEN_RESET;
            r_show_offset <= 1'b0;
            r_run_len     <= '0;
            r_byte_pos    <= '0;
            r_run_start   <= '0;
        end else begin
            r_run_len   <= n_run_len;
            r_byte_pos  <= n_byte_pos;
            r_run_start <= n_run_start;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_LEN:     r_min_len     <= i_cfg_data;
                    CFG_SHOW_OFFSET: r_show_offset <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/pre_cmdq.sv =====
// Short command queue between the front and back ends.
// Depends on pre_pkg and the assertion macro header.
`default_nettype none
`include "printable_run_extractor_unit_defines.svh"

module pre_cmdq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pre_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output pre_pkg::t_cmdq_status o_status,
    output pre_pkg::t_cmd      o_cmd
);
    import pre_pkg::*;

    t_cmd                  r_slot [0:CMDQ_DEPTH-1];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_cmd          = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `PRE_ASSERT_NEVER(a_cmdq_overflow, i_push && o_status.full, "command queue overflow")
    `PRE_ASSERT_NEVER(a_cmdq_underflow, i_pop && !o_status.valid, "command queue underflow")

endmodule

`default_nettype wire

// ===== design/pre_back.sv =====
// Back end: holds the run buffer, executes commands, drives the output register.
// Depends on pre_pkg and the assertion macro header.
`default_nettype none
`include "printable_run_extractor_unit_defines.svh"

module pre_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  wire pre_pkg::t_cmd              i_q_cmd,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_kind,
    output logic [pre_pkg::CHAR_W-1:0]      o_out_char,
    output logic [pre_pkg::OFF_W-1:0]       o_start_offset,
    output logic                            o_has_offset,
    output logic                            o_last
);
    import pre_pkg::*;

    logic [CHAR_W-1:0] r_buf [0:MAX_MIN_LEN-1];
    logic [CHAR_W-1:0] r_rd_data;

    t_bk_state        r_state, n_state;
    logic [IDX_W-1:0] r_idx,   n_idx;

    logic              r_b_valid,    n_b_valid;
    logic              r_b_kind,     n_b_kind;
    logic              r_b_from_mem, n_b_from_mem;
    logic [CHAR_W-1:0] r_b_char,     n_b_char;
    logic [OFF_W-1:0]  r_b_off,      n_b_off;
    logic              r_b_has_off,  n_b_has_off;
    logic              r_b_last,     n_b_last;

    logic             adv;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    always_comb begin
        adv          = !r_b_valid || !i_out_stall;
        n_state      = r_state;
        n_idx        = r_idx;
        o_pop        = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_idx;
        n_b_valid    = r_b_valid && i_out_stall;
        n_b_kind     = r_b_kind;
        n_b_from_mem = r_b_from_mem;
        n_b_char     = r_b_char;
        n_b_off      = r_b_off;
        n_b_has_off  = r_b_has_off;
        n_b_last     = r_b_last;

        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.op)
                        OP_STORE: begin
                            wr_en = 1'b1;
                            o_pop = 1'b1;
                        end
                        OP_EMIT, OP_LINE_END: begin
                            if (adv) begin
                                n_b_valid    = 1'b1;
                                n_b_kind     = (i_q_cmd.op == OP_LINE_END);
                                n_b_from_mem = 1'b0;
                                n_b_char     = (i_q_cmd.op == OP_LINE_END) ? '0 : i_q_cmd.ch;
                                n_b_off      = '0;
                                n_b_has_off  = 1'b0;
                                n_b_last     = 1'b1;
                                o_pop        = 1'b1;
                            end
                        end
                        OP_FLUSH: begin
                            if (adv) begin
                                n_b_valid   = 1'b1;
                                n_b_kind    = 1'b0;
                                n_b_char    = i_q_cmd.ch;
                                n_b_has_off = i_q_cmd.show;
                                n_b_off     = i_q_cmd.show ? i_q_cmd.offset : '0;
                                if (i_q_cmd.idx == '0) begin
                                    // nothing buffered: current character opens the run
                                    n_b_from_mem = 1'b0;
                                    n_b_last     = 1'b1;
                                    o_pop        = 1'b1;
                                end else begin
                                    rd_en        = 1'b1;
                                    rd_addr      = '0;
                                    n_b_from_mem = 1'b1;
                                    n_b_last     = 1'b0;
                                    n_idx        = IDX_W'(1);
                                    n_state      = BK_FLUSH;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_FLUSH: begin
                if (adv) begin
                    n_b_valid   = 1'b1;
                    n_b_kind    = 1'b0;
                    n_b_char    = i_q_cmd.ch;
                    n_b_off     = '0;
                    n_b_has_off = 1'b0;
                    if (r_idx < i_q_cmd.idx) begin
                        rd_en        = 1'b1;
                        n_b_from_mem = 1'b1;
                        n_b_last     = 1'b0;
                        n_idx        = r_idx + 1'b1;
                    end else begin
                        // buffer drained: close with the character that triggered it
                        n_b_from_mem = 1'b0;
                        n_b_last     = 1'b1;
                        o_pop        = 1'b1;
                        n_state      = BK_IDLE;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[i_q_cmd.idx] <= i_q_cmd.ch;
        end
        if (rd_en) begin
            r_rd_data <= r_buf[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_idx     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_b_valid <= n_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_kind     <= n_b_kind;
        r_b_from_mem <= n_b_from_mem;
        r_b_char     <= n_b_char;
        r_b_off      <= n_b_off;
        r_b_has_off  <= n_b_has_off;
        r_b_last     <= n_b_last;
    end

    assign o_out_valid    = r_b_valid;
    assign o_kind         = r_b_kind;
    assign o_out_char     = r_b_from_mem ? r_rd_data : r_b_char;
    assign o_start_offset = r_b_off;
    assign o_has_offset   = r_b_has_off;
    assign o_last         = r_b_last;

    `PRE_ASSERT_IMPLIES(a_flush_head, r_state == BK_FLUSH,
        i_q_valid && (i_q_cmd.op == OP_FLUSH) && (r_idx <= i_q_cmd.idx),
        "flush running without a matching command at the queue head")
    `PRE_ASSERT_IMPLIES(a_line_end_clean, r_b_valid && r_b_kind,
        !r_b_from_mem && (r_b_char == '0) && !r_b_has_off && r_b_last,
        "line end carries character or offset data")
    `PRE_ASSERT_NEXT(a_pop_ends_item, o_pop && (i_q_cmd.op != OP_STORE),
        o_out_valid && o_last, "retired command did not leave a final result")

endmodule

`default_nettype wire

// ===== design/printable_run_extractor_unit.sv =====
// Top level of the printable run extractor: front end, command queue, back end.
// Depends on pre_pkg, pre_front, pre_cmdq and pre_back.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+-------------------------------------------
//   in      | i_in_valid   | o_in_stall   | i_char_code i_byte_count i_printable
//           |              |              | i_decode_error
//   out     | o_out_valid  | i_out_stall  | o_kind o_out_char o_start_offset
//           |              |              | o_has_offset o_last
//   cfg     | i_cfg_we     | none         | i_cfg_idx i_cfg_data
//
// Input takes one character per cycle while the four-entry command queue has room.
// A run flush of N buffered characters yields N+1 results, the first N read from the
// run buffer port; the back end takes no other command until the flush is done.
// Input stalls only when the queue fills behind a flush or a stalled output.
// Reset is synchronous, active low; the run buffer needs no clearing pass.
`default_nettype none

module printable_run_extractor_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pre_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pre_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [pre_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic [pre_pkg::BCNT_W-1:0]     i_byte_count,
    input  wire logic                           i_printable,
    input  wire logic                           i_decode_error,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_kind,
    output logic [pre_pkg::CHAR_W-1:0]          o_out_char,
    output logic [pre_pkg::OFF_W-1:0]           o_start_offset,
    output logic                                o_has_offset,
    output logic                                o_last
);
    import pre_pkg::*;

    t_cmdq_status q_status;
    t_cmd         push_cmd;
    t_cmd         head_cmd;
    logic         push;
    logic         pop;

    pre_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_code    (i_char_code),
        .i_byte_count   (i_byte_count),
        .i_printable    (i_printable),
        .i_decode_error (i_decode_error),
        .i_q_status     (q_status),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    pre_cmdq u_cmdq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_status (q_status),
        .o_cmd    (head_cmd)
    );

    pre_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_status.valid),
        .i_q_cmd        (head_cmd),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_out_char     (o_out_char),
        .o_start_offset (o_start_offset),
        .o_has_offset   (o_has_offset),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ===== tb/pre_run_checker.sv =====
// Checker for the printable run extractor: tracks run state from the input
// transfers and config writes, predicts each output transfer and compares it.
// Depends on pre_pkg for field widths and register indexes.
`default_nettype none

module pre_run_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pre_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pre_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic [pre_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic [pre_pkg::BCNT_W-1:0]     i_byte_count,
    input  wire logic                           i_printable,
    input  wire logic                           i_decode_error,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic                           i_kind,
    input  wire logic [pre_pkg::CHAR_W-1:0]     i_out_char,
    input  wire logic [pre_pkg::OFF_W-1:0]      i_start_offset,
    input  wire logic                           i_has_offset,
    input  wire logic                           i_last,
    output int                                  o_pending,
    output int                                  o_errors
);
    import pre_pkg::*;

    localparam logic KIND_CHAR     = 1'b0;
    localparam logic KIND_LINE_END = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] ch;
        logic [OFF_W-1:0]  offset;
        logic              has_offset;
        logic              last;
    } t_run_result;

    t_run_result         expected_q [$];
    t_run_result         want;
    logic [CHAR_W-1:0]   held_chars [MAX_MIN_LEN];
    logic [RLEN_W-1:0]   run_len;
    logic [OFF_W-1:0]    byte_pos;
    logic [OFF_W-1:0]    run_origin;
    logic [MINLEN_W-1:0] min_len;
    logic                show_offset;

    task automatic queue_result(input logic kind, input logic [CHAR_W-1:0] ch,
                                input logic tag);
        t_run_result r;
        r.kind       = kind;
        r.ch         = ch;
        r.offset     = tag ? run_origin : '0;
        r.has_offset = tag;
        r.last       = 1'b0;
        expected_q.push_back(r);
    endtask

    task automatic extract_runs(input logic [CHAR_W-1:0] ch, input logic [BCNT_W-1:0] nbytes,
                                input logic prn, input logic err);
        logic [OFF_W-1:0] prior;
        int               base;
        int               i;
        prior    = byte_pos;
        byte_pos = byte_pos + OFF_W'(nbytes);
        base     = expected_q.size();
        if (err)
            return;
        if (!prn) begin
            if (run_len > RLEN_W'(min_len))
                queue_result(KIND_LINE_END, '0, 1'b0);
            run_len = '0;
        end else begin
            if (run_len == '0)
                run_origin = prior;
            if (run_len < RLEN_W'(min_len)) begin
                held_chars[run_len[IDX_W-1:0]] = ch;
                run_len = run_len + 1'b1;
            end else if (run_len > RLEN_W'(min_len)) begin
                queue_result(KIND_CHAR, ch, 1'b0);
            end else begin
                // run just crossed the threshold: flush the buffer, then this one
                for (i = 0; i < int'(min_len); i++)
                    queue_result(KIND_CHAR, held_chars[IDX_W'(i)], i == 0 && show_offset);
                queue_result(KIND_CHAR, ch, min_len == '0 && show_offset);
                run_len = RLEN_W'(min_len) + 1'b1;
            end
        end
        if (expected_q.size() > base)
            expected_q[expected_q.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [OFF_W-1:0] exp_v,
                               input logic [OFF_W-1:0] act_v);
        if (act_v !== exp_v) begin
            o_errors++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            run_len     = '0;
            byte_pos    = '0;
            run_origin  = '0;
            min_len     = MIN_LEN_RESET;
            show_offset = 1'b0;
            o_errors    = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MIN_LEN)
                    min_len = i_cfg_data[MINLEN_W-1:0];
                else if (i_cfg_idx == CFG_SHOW_OFFSET)
                    show_offset = i_cfg_data[0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result: expected none, got kind %0d char %0h",
                             $time, i_kind, i_out_char);
                end else begin
                    want = expected_q.pop_front();
                    check_field("kind", OFF_W'(want.kind), OFF_W'(i_kind));
                    check_field("out_char", OFF_W'(want.ch), OFF_W'(i_out_char));
                    check_field("start_offset", want.offset, i_start_offset);
                    check_field("has_offset", OFF_W'(want.has_offset), OFF_W'(i_has_offset));
                    check_field("last", OFF_W'(want.last), OFF_W'(i_last));
                end
            end
            if (i_in_valid && !i_in_stall)
                extract_runs(i_char_code, i_byte_count, i_printable, i_decode_error);
        end
        o_pending = expected_q.size();
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench top for printable_run_extractor_unit: clock, reset, character
// stimulus, output stall pattern and the verdict. Depends on pre_pkg and pre_run_checker.
`default_nettype none

module tb_top;
    import pre_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 32;
    localparam int TARGET_CHARS  = 240;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [CHAR_W-1:0]     char_code;
    logic [BCNT_W-1:0]     byte_count;
    logic                  printable;
    logic                  decode_error;
    logic                  out_valid;
    logic                  out_stall;
    logic                  kind;
    logic [CHAR_W-1:0]     out_char;
    logic [OFF_W-1:0]      start_offset;
    logic                  has_offset;
    logic                  out_last;
    int                    pending;
    int                    errors;

    bit                    idle_in;
    bit                    idle_out;
    bit                    hold_req;
    int                    out_gap;
    int                    chars_sent;
    int                    phase;
    logic [MINLEN_W-1:0]   cur_min_len;

    printable_run_extractor_unit DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_char_code    (char_code),
        .i_byte_count   (byte_count),
        .i_printable    (printable),
        .i_decode_error (decode_error),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_kind         (kind),
        .o_out_char     (out_char),
        .o_start_offset (start_offset),
        .o_has_offset   (has_offset),
        .o_last         (out_last)
    );

    pre_run_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_char_code    (char_code),
        .i_byte_count   (byte_count),
        .i_printable    (printable),
        .i_decode_error (decode_error),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_kind         (kind),
        .i_out_char     (out_char),
        .i_start_offset (start_offset),
        .i_has_offset   (has_offset),
        .i_last         (out_last),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random stall before each transfer, one long hold on request.
    initial begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_gap = idle_out ? $urandom_range(0, 10) : 0;
            if (out_gap != 0) begin
                out_stall = 1'b1;
                repeat (out_gap) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    function automatic logic [CHAR_W-1:0] rand_char();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            return CHAR_W'($urandom_range(32, 126));
        else if (pick == 1)
            return $urandom_range(0, 1) ? 21'h10FFFF : 21'h0FFFFF;
        else if (pick == 2)
            return '0;
        return CHAR_W'($urandom_range(0, 21'h10FFFF));
    endfunction

    function automatic logic [BCNT_W-1:0] rand_bytes();
        if ($urandom_range(0, 9) < 8)
            return BCNT_W'($urandom_range(1, 4));
        return BCNT_W'($urandom_range(0, 7));
    endfunction

    // Offer one character and hold it until the transfer.
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic [BCNT_W-1:0] nbytes,
                             input logic prn, input logic err);
        int gap;
        gap = idle_in ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        char_code    = ch;
        byte_count   = nbytes;
        printable    = prn;
        decode_error = err;
        do @(posedge clk); while (in_stall !== 1'b0);
        @(negedge clk);
        if (!err)
            chars_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        // buffered characters leave no result to wait for
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic next_setting(input logic [MINLEN_W-1:0] new_len, input bit new_show,
                                input bit close);
        // a raised threshold on an open run would read buffer slots never filled
        if (close || new_len > cur_min_len)
            send_char(rand_char(), rand_bytes(), 1'b0, 1'b0);
        drain();
        write_reg(CFG_MIN_LEN, new_len);
        write_reg(CFG_SHOW_OFFSET, {{(CFG_DATA_W-1){1'b0}}, new_show});
        cur_min_len = new_len;
    endtask

    // A printable run with stray decode errors, then a breaker or a decode error.
    task automatic send_run(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_char(rand_char(), rand_bytes(), 1'($urandom_range(0, 1)), 1'b1);
            send_char(rand_char(), rand_bytes(), 1'b1, 1'b0);
        end
        send_char(rand_char(), rand_bytes(), 1'b0, $urandom_range(0, 7) == 0);
    endtask

    task automatic run_phase(input int n_chars);
        int target;
        int len;
        target = chars_sent + n_chars;
        while (chars_sent < target) begin
            if ($urandom_range(0, 4) == 0) begin
                send_char(rand_char(), rand_bytes(), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 3) == 0);
            end else begin
                if ($urandom_range(0, 1))
                    len = $urandom_range(int'(cur_min_len) + 1, int'(cur_min_len) + 4);
                else
                    len = $urandom_range(0, int'(cur_min_len) + 4);
                send_run(len);
            end
        end
    endtask

    function automatic logic [MINLEN_W-1:0] rand_min_len();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return MINLEN_W'($urandom_range(9, 20));
        return MINLEN_W'($urandom_range(1, 8));
    endfunction

    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        char_code    = '0;
        byte_count   = '0;
        printable    = 1'b0;
        decode_error = 1'b0;
        idle_in      = 1'b1;
        idle_out     = 1'b1;
        hold_req     = 1'b0;
        chars_sent   = 0;
        cur_min_len  = MIN_LEN_RESET;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: threshold 4, no offsets
        send_char(21'h000000, 3'd1, 1'b1, 1'b0);
        send_char(21'h10FFFF, 3'd4, 1'b1, 1'b0);
        send_char(21'h001234, 3'd7, 1'b1, 1'b1);   // error beats printable
        send_char(21'h0FFFFF, 3'd0, 1'b1, 1'b0);
        send_char(21'h0AAAAA, 3'd5, 1'b1, 1'b0);
        send_char(21'h055555, 3'd6, 1'b1, 1'b0);   // crosses threshold: flush
        send_char(21'h000041, 3'd2, 1'b1, 1'b0);
        send_char(21'h00000A, 3'd1, 1'b0, 1'b0);   // line end
        send_char(21'h000000, 3'd3, 1'b0, 1'b1);
        send_char(21'h000020, 3'd1, 1'b0, 1'b0);   // no run open: nothing

        // zero threshold: every printable goes out at once
        next_setting(6'd0, 1'b1, 1'b0);
        send_char(21'h000048, 3'd1, 1'b1, 1'b0);
        send_char(21'h10FFFF, 3'd4, 1'b1, 1'b0);
        send_char(21'h000000, 3'd2, 1'b0, 1'b0);

        next_setting(6'd1, 1'b1, 1'b1);
        send_char(21'h000061, 3'd2, 1'b1, 1'b0);
        send_char(21'h000062, 3'd3, 1'b1, 1'b0);
        send_char(21'h00007F, 3'd1, 1'b0, 1'b0);
        send_char(21'h000064, 3'd1, 1'b1, 1'b0);

        // lower the threshold under an open run: buffered character is dropped
        next_setting(6'd0, 1'b0, 1'b0);
        send_char(21'h000065, 3'd1, 1'b1, 1'b0);
        send_char(21'h000000, 3'd1, 1'b0, 1'b0);

        phase = 0;
        while (chars_sent < TARGET_CHARS + 20) begin
            idle_in  = $urandom_range(0, 3) != 0;
            idle_out = $urandom_range(0, 3) != 0;
            case (phase)
                0: begin
                    // long receiver hold with the sender at full rate
                    next_setting(6'd1, 1'b1, 1'b1);
                    idle_in  = 1'b0;
                    hold_req = 1'b1;
                    run_phase(40);
                end
                1: begin
                    next_setting(6'd63, 1'($urandom_range(0, 1)), 1'b1);
                    run_phase(64);
                end
                2: begin
                    next_setting(rand_min_len(), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                    run_phase(12);
                    in_valid = 1'b0;
                    while (pending != 0)
                        @(negedge clk);
                    run_phase(12);
                end
                default: begin
                    next_setting(rand_min_len(), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                    run_phase($urandom_range(10, 30));
                end
            endcase
            phase++;
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== printable_run_extractor_unit.f =====
+incdir+design
design/pre_pkg.sv
design/pre_front.sv
design/pre_cmdq.sv
design/pre_back.sv
design/printable_run_extractor_unit.sv
tb/pre_run_checker.sv
tb/tb_top.sv
